/* rtl/pse_pkg.sv */
// ----------------------------------------------------------------------------
// pse_pkg
// Shared types, constants and helpers for the postfix stack evaluator.
// ----------------------------------------------------------------------------
package pse_pkg;

  // Stack geometry
  localparam int STACK_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 32;

  // Character codes
  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_9   = 8'h39;
  localparam logic [7:0] CH_ADD = 8'h2B;
  localparam logic [7:0] CH_SUB = 8'h2D;
  localparam logic [7:0] CH_MUL = 8'h2A;
  localparam logic [7:0] CH_DIV = 8'h2F;

  // Operation classes of one character
  typedef enum logic [2:0] {
    OP_DIGIT,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_NONE
  } op_t;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_POP2,
    S_POP1,
    S_EXEC,
    S_CALC,
    S_DIVW,
    S_PUSH,
    S_FPOP,
    S_FEMIT
  } state_t;

  // Sticky error flags
  typedef struct packed {
    logic div0;
    logic unf;
    logic ovf;
  } flags_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic pop;
    logic take_op2;
    logic take_op1;
    logic alu;
    logic div_start;
    logic div_take;
    logic push;
    logic emit;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_digit;
    op_t  op;
    logic last;
    logic op2_zero;
    logic div_done;
    logic out_free;
  } stat_t;

  function automatic logic is_digit(input logic [7:0] sym);
    return (sym >= CH_0) && (sym <= CH_9);
  endfunction

  function automatic op_t decode_op(input logic [7:0] sym);
    op_t op;
    if (is_digit(sym)) begin
      op = OP_DIGIT;
    end else begin
      unique case (sym)
        CH_ADD:  op = OP_ADD;
        CH_SUB:  op = OP_SUB;
        CH_MUL:  op = OP_MUL;
        CH_DIV:  op = OP_DIV;
        default: op = OP_NONE;
      endcase
    end
    return op;
  endfunction

endpackage

/* rtl/pse_div.sv */
// ----------------------------------------------------------------------------
// pse_div
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module pse_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [pse_pkg::DATA_W-1:0]       dividend,
  input  logic [pse_pkg::DATA_W-1:0]       divisor,
  output logic                             done,
  output logic [pse_pkg::DATA_W-1:0]       quotient
);

  localparam int STEP_W = $clog2(pse_pkg::DATA_W);

  logic                        busy_r;
  logic                        done_r;
  logic [STEP_W-1:0]           cnt_r;
  logic                        neg_r;
  logic [pse_pkg::DATA_W-1:0]  rem_r;
  logic [pse_pkg::DATA_W-1:0]  quo_r;
  logic [pse_pkg::DATA_W-1:0]  mb_r;
  logic [pse_pkg::DATA_W:0]    trial;
  logic                        fits;
  logic [pse_pkg::DATA_W-1:0]  ma;
  logic [pse_pkg::DATA_W-1:0]  mb;

  // operand magnitudes
  assign ma = dividend[pse_pkg::DATA_W-1] ? (pse_pkg::DATA_W'(0) - dividend) : dividend;
  assign mb = divisor[pse_pkg::DATA_W-1]  ? (pse_pkg::DATA_W'(0) - divisor)  : divisor;

  // restoring step
  assign trial = {rem_r, quo_r[pse_pkg::DATA_W-1]};
  assign fits  = trial >= {1'b0, mb_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '1;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[pse_pkg::DATA_W-1] ^ divisor[pse_pkg::DATA_W-1];
      rem_r <= '0;
      quo_r <= ma;
      mb_r  <= mb;
    end else if (busy_r) begin
      rem_r <= fits ? pse_pkg::DATA_W'(trial - {1'b0, mb_r}) : trial[pse_pkg::DATA_W-1:0];
      quo_r <= {quo_r[pse_pkg::DATA_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? (pse_pkg::DATA_W'(0) - quo_r) : quo_r;

endmodule

/* rtl/pse_ctrl.sv */
// ----------------------------------------------------------------------------
// pse_ctrl
// Sequencer: steps one character through pop, compute, push and emit.
// ----------------------------------------------------------------------------
module pse_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  pse_pkg::stat_t  stat,
  output pse_pkg::cmd_t   cmd
);

  pse_pkg::state_t state_r;
  pse_pkg::state_t state_nxt;
  logic            accept;

  assign accept = in_tvalid && (state_r == pse_pkg::S_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pse_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pse_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = stat.in_digit ? pse_pkg::S_PUSH : pse_pkg::S_POP2;
        end
      end
      pse_pkg::S_POP2: state_nxt = pse_pkg::S_POP1;
      pse_pkg::S_POP1: state_nxt = pse_pkg::S_EXEC;
      pse_pkg::S_EXEC: state_nxt = pse_pkg::S_CALC;
      pse_pkg::S_CALC: begin
        unique case (stat.op)
          pse_pkg::OP_ADD, pse_pkg::OP_SUB, pse_pkg::OP_MUL: state_nxt = pse_pkg::S_PUSH;
          pse_pkg::OP_DIV: state_nxt = stat.op2_zero ? pse_pkg::S_PUSH : pse_pkg::S_DIVW;
          default:         state_nxt = stat.last ? pse_pkg::S_FPOP : pse_pkg::S_IDLE;
        endcase
      end
      pse_pkg::S_DIVW: begin
        if (stat.div_done) begin
          state_nxt = pse_pkg::S_PUSH;
        end
      end
      pse_pkg::S_PUSH: state_nxt = stat.last ? pse_pkg::S_FPOP : pse_pkg::S_IDLE;
      pse_pkg::S_FPOP: state_nxt = pse_pkg::S_FEMIT;
      pse_pkg::S_FEMIT: begin
        if (stat.out_free) begin
          state_nxt = pse_pkg::S_IDLE;
        end
      end
      default: state_nxt = pse_pkg::S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      pse_pkg::S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = accept;
      end
      pse_pkg::S_POP2: cmd.pop = 1'b1;
      pse_pkg::S_POP1: begin
        cmd.pop      = 1'b1;
        cmd.take_op2 = 1'b1;
      end
      pse_pkg::S_EXEC: cmd.take_op1 = 1'b1;
      pse_pkg::S_CALC: begin
        cmd.alu       = 1'b1;
        cmd.div_start = (stat.op == pse_pkg::OP_DIV) && !stat.op2_zero;
      end
      pse_pkg::S_DIVW:  cmd.div_take = stat.div_done;
      pse_pkg::S_PUSH:  cmd.push = 1'b1;
      pse_pkg::S_FPOP:  cmd.pop = 1'b1;
      pse_pkg::S_FEMIT: cmd.emit = stat.out_free;
      default: ;
    endcase
  end

endmodule

/* rtl/pse_dp.sv */
// ----------------------------------------------------------------------------
// pse_dp
// Datapath: stack memory, operand registers, ALU, divider and result stage.
// ----------------------------------------------------------------------------
module pse_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [7:0]                  in_symbol,
  input  logic                        in_last,
  input  pse_pkg::cmd_t               cmd,
  output pse_pkg::stat_t              stat,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [pse_pkg::DATA_W-1:0]  out_value,
  output pse_pkg::flags_t             out_flags
);

  logic [pse_pkg::DATA_W-1:0]  mem_r [pse_pkg::STACK_DEPTH];
  logic [pse_pkg::CNT_W-1:0]   count_r;
  logic [pse_pkg::DATA_W-1:0]  rd_data_r;
  logic                        pop_empty_r;
  pse_pkg::flags_t             flags_r;
  pse_pkg::op_t                op_r;
  logic                        last_r;
  logic [pse_pkg::DATA_W-1:0]  op1_r;
  logic [pse_pkg::DATA_W-1:0]  op2_r;
  logic [pse_pkg::DATA_W-1:0]  res_r;
  logic                        out_valid_r;
  logic [pse_pkg::DATA_W-1:0]  out_value_r;
  pse_pkg::flags_t             out_flags_r;

  logic                        empty;
  logic                        full;
  logic [pse_pkg::ADDR_W-1:0]  wr_addr;
  logic [pse_pkg::ADDR_W-1:0]  rd_addr;
  logic [pse_pkg::DATA_W-1:0]  popped;
  logic [pse_pkg::CNT_W-1:0]   count_dec;
  logic [7:0]                  digit_val;
  logic                        div_done;
  logic [pse_pkg::DATA_W-1:0]  div_q;

  assign empty     = (count_r == '0);
  assign full      = (count_r == pse_pkg::CNT_W'(pse_pkg::STACK_DEPTH));
  assign count_dec = count_r - 1'b1;
  assign wr_addr   = count_r[pse_pkg::ADDR_W-1:0];
  assign rd_addr   = count_dec[pse_pkg::ADDR_W-1:0];
  // an empty pop reads as all ones
  assign popped    = pop_empty_r ? '1 : rd_data_r;
  assign digit_val = in_symbol - pse_pkg::CH_0;

  // stack memory
  always_ff @(posedge clk) begin
    if (cmd.push && !full) begin
      mem_r[wr_addr] <= res_r;
    end
    if (cmd.pop) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  // stack pointer, sticky flags and result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      flags_r     <= '0;
      pop_empty_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.pop) begin
        pop_empty_r <= empty;
        if (empty) begin
          flags_r.unf <= 1'b1;
        end else begin
          count_r <= count_dec;
        end
      end
      if (cmd.push) begin
        if (full) begin
          flags_r.ovf <= 1'b1;
        end else begin
          count_r <= count_r + 1'b1;
        end
      end
      if (cmd.alu && (op_r == pse_pkg::OP_DIV) && (op2_r == '0)) begin
        flags_r.div0 <= 1'b1;
      end
      // emit clears the expression state
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        count_r     <= '0;
        flags_r     <= '0;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // operand and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= pse_pkg::decode_op(in_symbol);
      last_r <= in_last;
      res_r  <= pse_pkg::DATA_W'(digit_val);
    end
    if (cmd.take_op2) begin
      op2_r <= popped;
    end
    if (cmd.take_op1) begin
      op1_r <= popped;
    end
    if (cmd.alu) begin
      unique case (op_r)
        pse_pkg::OP_ADD: res_r <= op1_r + op2_r;
        pse_pkg::OP_SUB: res_r <= op1_r - op2_r;
        pse_pkg::OP_MUL: res_r <= op1_r * op2_r;
        pse_pkg::OP_DIV: res_r <= '0;
        default: ;
      endcase
    end
    if (cmd.div_take) begin
      res_r <= div_q;
    end
    if (cmd.emit) begin
      out_value_r <= popped;
      out_flags_r <= flags_r;
    end
  end

  pse_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (op1_r),
    .divisor  (op2_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // status to the sequencer
  assign stat.in_digit = pse_pkg::is_digit(in_symbol);
  assign stat.op       = op_r;
  assign stat.last     = last_r;
  assign stat.op2_zero = (op2_r == '0);
  assign stat.div_done = div_done;
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_flags = out_flags_r;

endmodule

/* rtl/postfix_stack_evaluator.sv */
// ----------------------------------------------------------------------------
// postfix_stack_evaluator
// Evaluates a postfix expression, one character per item, on a 64-word stack.
// ----------------------------------------------------------------------------
// A digit is pushed once taken; an operator pops two operands, computes and
// pushes the result, a nonzero divide waiting on the one-bit-per-cycle serial
// divider. On the last item the final value is popped and emitted; the result
// then sits in the output register and the next item is taken while it waits.
// Reset (rst_n low, synchronous) empties the stack, clears the flags and
// drops any pending result; the stack words themselves are not cleared.
module postfix_stack_evaluator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] symbol
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] value
  output logic [2:0]  out_tuser   // [0] overflow_seen, [1] underflow_seen,
                                  // [2] divide_by_zero_seen
);

  pse_pkg::cmd_t   cmd;
  pse_pkg::stat_t  stat;
  pse_pkg::flags_t flags;

  pse_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pse_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_symbol (in_tdata),
    .in_last   (in_tlast),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_value (out_tdata),
    .out_flags (flags)
  );

  assign out_tuser = {flags.div0, flags.unf, flags.ovf};

endmodule

/* rtl/pse_chk.sv */
// ----------------------------------------------------------------------------
// pse_chk
// Port-level checks for the postfix stack evaluator.
// ----------------------------------------------------------------------------
module pse_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [2:0]  out_tuser
);

  // a stalled result holds its contents
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // reset drops any pending result
  a_rst_clear: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // one item at a time: busy straight after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item taken while previous one in progress");

  // only a last item can raise a result
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tlast |=> !$rose(out_tvalid) ##1 !$rose(out_tvalid))
    else $error("result without a last item");

endmodule

bind postfix_stack_evaluator pse_chk u_pse_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
